### sv/saeq_pkg.sv
package saeq_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int STATE_BITS  = 40;
	localparam int WIDE_BITS   = 48;
	localparam int OPA_BITS    = 42;
	localparam int OPB_BITS    = 20;
	localparam int PROD_BITS   = 46;
	localparam int UP_SHIFT    = 32 - SAMPLE_BITS;
	localparam int X_BITS      = 32;
	localparam int SEQ_LEN     = 16;
	localparam int SEQ_BITS    = $clog2(SEQ_LEN);
	localparam logic [16:0] UNITY    = 17'd65536;
	localparam logic [15:0] IQ_RESET = 16'd31208;

	typedef enum logic [2:0] {
		REG_HIGH = 3'd0,
		REG_TRIP = 3'd1,
		REG_AIR  = 3'd2,
		REG_IQ   = 3'd3,
		REG_OG   = 3'd4,
		REG_WET  = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		STEP_TRIP,
		STEP_TCORR,
		STEP_TSC0,
		STEP_TSC1,
		STEP_TSC2,
		STEP_AUPD,
		STEP_ACORR,
		STEP_AODD,
		STEP_AEVEN,
		STEP_Y,
		STEP_WET,
		STEP_DRY
	} step_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_RUN,
		CS_PUSH
	} ctrl_state_t;

	typedef struct packed {
		step_t step;
		logic  issue;
		logic  wb;
		logic  ch;
		logic  stg;
		logic  load;
		logic  push;
	} cmd_t;

	function automatic step_t seq_step(logic [SEQ_BITS-1:0] idx);
		step_t s;
		unique case (idx)
			4'd0:  s = STEP_TRIP;
			4'd1:  s = STEP_TCORR;
			4'd2:  s = STEP_TSC0;
			4'd3:  s = STEP_TSC1;
			4'd4:  s = STEP_TSC2;
			4'd5:  s = STEP_AUPD;
			4'd6:  s = STEP_ACORR;
			4'd7:  s = STEP_AODD;
			4'd8:  s = STEP_AEVEN;
			4'd9:  s = STEP_AUPD;
			4'd10: s = STEP_ACORR;
			4'd11: s = STEP_AODD;
			4'd12: s = STEP_AEVEN;
			4'd13: s = STEP_Y;
			4'd14: s = STEP_WET;
			default: s = STEP_DRY;
		endcase
		return s;
	endfunction

	function automatic logic signed [STATE_BITS-1:0] sat_state(logic signed [WIDE_BITS-1:0] v);
		logic signed [WIDE_BITS-1:0] hi;
		logic signed [WIDE_BITS-1:0] lo;
		hi = (WIDE_BITS'(1) <<< (STATE_BITS - 1)) - WIDE_BITS'(1);
		lo = -hi - WIDE_BITS'(1);
		if (v > hi)
			return hi[STATE_BITS-1:0];
		else if (v < lo)
			return lo[STATE_BITS-1:0];
		return v[STATE_BITS-1:0];
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(logic signed [WIDE_BITS-1:0] v);
		logic signed [WIDE_BITS-1:0] hi;
		logic signed [WIDE_BITS-1:0] lo;
		hi = (WIDE_BITS'(1) <<< (SAMPLE_BITS - 1)) - WIDE_BITS'(1);
		lo = -hi - WIDE_BITS'(1);
		if (v > hi)
			return hi[SAMPLE_BITS-1:0];
		else if (v < lo)
			return lo[SAMPLE_BITS-1:0];
		return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

### sv/saeq_ctrl.sv
module saeq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output saeq_pkg::cmd_t    cmd
);

	saeq_pkg::ctrl_state_t state_q, state_d;
	logic [saeq_pkg::SEQ_BITS-1:0] idx_q, idx_d;
	logic ch_q, ch_d;
	logic ph_q, ph_d;
	logic out_valid_q, out_valid_d;
	saeq_pkg::step_t step;
	logic is_mul;

	assign step = saeq_pkg::seq_step(idx_q);
	assign is_mul = !(step == saeq_pkg::STEP_TRIP || step == saeq_pkg::STEP_AUPD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= saeq_pkg::CS_IDLE;
			idx_q       <= '0;
			ch_q        <= 1'b0;
			ph_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			ch_q        <= ch_d;
			ph_q        <= ph_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		ch_d        = ch_q;
		ph_d        = ph_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.step    = step;
		cmd.ch      = ch_q;
		cmd.stg     = (idx_q > saeq_pkg::SEQ_BITS'(8));
		unique case (state_q)
			saeq_pkg::CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = saeq_pkg::CS_RUN;
					idx_d    = '0;
					ch_d     = 1'b0;
					ph_d     = 1'b0;
				end
			end
			saeq_pkg::CS_RUN: begin
				if (is_mul && !ph_q) begin
					cmd.issue = 1'b1;
					ph_d      = 1'b1;
				end else begin
					cmd.wb = 1'b1;
					ph_d   = 1'b0;
					if (idx_q == saeq_pkg::SEQ_BITS'(saeq_pkg::SEQ_LEN - 1)) begin
						idx_d = '0;
						if (ch_q)
							state_d = saeq_pkg::CS_PUSH;
						else
							ch_d = 1'b1;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: begin
				if (!out_valid_q || out_ready) begin
					cmd.push    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = saeq_pkg::CS_IDLE;
				end
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### sv/saeq_dp.sv
module saeq_dp (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  saeq_pkg::cmd_t                           cmd,
	input  logic signed [saeq_pkg::SAMPLE_BITS-1:0]  in_left,
	input  logic signed [saeq_pkg::SAMPLE_BITS-1:0]  in_right,
	input  logic                                     cfg_we,
	input  logic [2:0]                               cfg_index,
	input  logic [18:0]                              cfg_data,
	output logic signed [saeq_pkg::SAMPLE_BITS-1:0]  out_left,
	output logic signed [saeq_pkg::SAMPLE_BITS-1:0]  out_right
);

	localparam int SB = saeq_pkg::STATE_BITS;
	localparam int WB = saeq_pkg::WIDE_BITS;

	logic signed [18:0] high_q;
	logic signed [17:0] trip_q;
	logic signed [16:0] air_q;
	logic [15:0] iq_q;
	logic [16:0] og_q;
	logic [16:0] wet_q;

	logic signed [SB-1:0] tprev_q [2];
	logic signed [SB-1:0] tmid_q [2];
	logic signed [SB-1:0] acc_q [2][3];
	logic signed [SB-1:0] aprev_q [2][3];
	logic signed [SB-1:0] even_q [2][3];
	logic signed [SB-1:0] odd_q [2][3];
	logic [1:0] phase_q;
	logic alt_q, flip1_q, flip2_q;

	logic signed [saeq_pkg::SAMPLE_BITS-1:0] smp_q [2];
	logic signed [saeq_pkg::SAMPLE_BITS-1:0] res_q [2];
	logic signed [saeq_pkg::SAMPLE_BITS-1:0] out_l_q, out_r_q;
	logic signed [WB-1:0] corr_q;
	logic signed [saeq_pkg::OPA_BITS-1:0] y_q;
	logic signed [WB-1:0] mix_q;
	logic signed [saeq_pkg::PROD_BITS-1:0] prod_q;

	logic [1:0] ph_eff, k, pk, si;
	logic use_even;
	logic signed [19:0] gain;
	logic signed [saeq_pkg::X_BITS-1:0] x;
	logic [16:0] wet_c, dry;
	logic signed [WB-1:0] pw, f_t, f_a, d_oe, d_eo, t_odd, t_even, ysum;
	logic signed [saeq_pkg::OPA_BITS-1:0] opa;
	logic signed [saeq_pkg::OPB_BITS-1:0] opb;
	logic signed [saeq_pkg::OPA_BITS+saeq_pkg::OPB_BITS-1:0] full;

	always_comb begin
		ph_eff = (phase_q == 2'd0) ? 2'd1 : phase_q;
		k = ph_eff - 2'd1;
		unique case (k)
			2'd0: pk = 2'd2;
			2'd1: pk = 2'd0;
			default: pk = 2'd1;
		endcase
		if (cmd.stg) begin
			si       = 2'd2;
			use_even = alt_q;
			gain     = 20'(high_q);
		end else begin
			si       = alt_q ? 2'd0 : 2'd1;
			use_even = alt_q ? flip1_q : flip2_q;
			gain     = 20'(air_q);
		end
		x = saeq_pkg::X_BITS'(smp_q[cmd.ch]) <<< saeq_pkg::UP_SHIFT;
		wet_c = (wet_q > saeq_pkg::UNITY) ? saeq_pkg::UNITY : wet_q;
		dry = saeq_pkg::UNITY - wet_c;
		pw = WB'(prod_q);
		f_t = WB'(tprev_q[cmd.ch]) - WB'(x);
		f_a = WB'(aprev_q[cmd.ch][si]) - WB'(x);
		d_oe = WB'(odd_q[cmd.ch][si]) - WB'(even_q[cmd.ch][si]);
		d_eo = WB'(even_q[cmd.ch][si]) - WB'(odd_q[cmd.ch][si]);
		t_odd = WB'(odd_q[cmd.ch][si]) - (d_oe >>> 8);
		t_even = WB'(even_q[cmd.ch][si]) - (d_eo >>> 8);
		ysum = WB'(saeq_pkg::sat_state(WB'(x) + corr_q));
		opa = '0;
		opb = '0;
		unique case (cmd.step)
			saeq_pkg::STEP_TCORR: begin
				opa = saeq_pkg::OPA_BITS'(acc_q[cmd.ch][k]);
				opb = saeq_pkg::OPB_BITS'(trip_q);
			end
			saeq_pkg::STEP_TSC0: begin
				opa = saeq_pkg::OPA_BITS'(acc_q[cmd.ch][0]);
				opb = saeq_pkg::OPB_BITS'({1'b0, iq_q});
			end
			saeq_pkg::STEP_TSC1: begin
				opa = saeq_pkg::OPA_BITS'(acc_q[cmd.ch][1]);
				opb = saeq_pkg::OPB_BITS'({1'b0, iq_q});
			end
			saeq_pkg::STEP_TSC2: begin
				opa = saeq_pkg::OPA_BITS'(acc_q[cmd.ch][2]);
				opb = saeq_pkg::OPB_BITS'({1'b0, iq_q});
			end
			saeq_pkg::STEP_ACORR: begin
				opa = saeq_pkg::OPA_BITS'(use_even ? even_q[cmd.ch][si] : odd_q[cmd.ch][si]);
				opb = gain;
			end
			saeq_pkg::STEP_AODD: begin
				opa = saeq_pkg::OPA_BITS'(t_odd);
				opb = saeq_pkg::OPB_BITS'({1'b0, iq_q});
			end
			saeq_pkg::STEP_AEVEN: begin
				opa = saeq_pkg::OPA_BITS'(t_even);
				opb = saeq_pkg::OPB_BITS'({1'b0, iq_q});
			end
			saeq_pkg::STEP_Y: begin
				opa = saeq_pkg::OPA_BITS'(ysum);
				opb = saeq_pkg::OPB_BITS'({1'b0, og_q});
			end
			saeq_pkg::STEP_WET: begin
				opa = y_q;
				opb = saeq_pkg::OPB_BITS'({1'b0, wet_c});
			end
			saeq_pkg::STEP_DRY: begin
				opa = saeq_pkg::OPA_BITS'(x);
				opb = saeq_pkg::OPB_BITS'({1'b0, dry});
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		full = opa * opb;
	end

	always_ff @(posedge clk) begin
		if (cmd.issue)
			prod_q <= full[saeq_pkg::PROD_BITS+15:16];
		if (cmd.load) begin
			smp_q[0] <= in_left;
			smp_q[1] <= in_right;
		end
		if (cmd.wb) begin
			unique case (cmd.step)
				saeq_pkg::STEP_TCORR: corr_q <= pw;
				saeq_pkg::STEP_ACORR: corr_q <= corr_q + pw;
				saeq_pkg::STEP_Y:     y_q <= prod_q[saeq_pkg::OPA_BITS-1:0];
				saeq_pkg::STEP_WET:   mix_q <= pw;
				saeq_pkg::STEP_DRY:
					res_q[cmd.ch] <= saeq_pkg::sat_sample((mix_q + pw) >>> saeq_pkg::UP_SHIFT);
				default: ;
			endcase
		end
		if (cmd.push) begin
			out_l_q <= res_q[0];
			out_r_q <= res_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q  <= '0;
			trip_q  <= '0;
			air_q   <= '0;
			iq_q    <= saeq_pkg::IQ_RESET;
			og_q    <= saeq_pkg::UNITY;
			wet_q   <= saeq_pkg::UNITY;
			tprev_q <= '{default: '0};
			tmid_q  <= '{default: '0};
			acc_q   <= '{default: '{default: '0}};
			aprev_q <= '{default: '{default: '0}};
			even_q  <= '{default: '{default: '0}};
			odd_q   <= '{default: '{default: '0}};
			phase_q <= 2'd1;
			alt_q   <= 1'b0;
			flip1_q <= 1'b0;
			flip2_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					saeq_pkg::REG_HIGH: high_q <= cfg_data;
					saeq_pkg::REG_TRIP: trip_q <= cfg_data[17:0];
					saeq_pkg::REG_AIR:  air_q <= cfg_data[16:0];
					saeq_pkg::REG_IQ:   iq_q <= cfg_data[15:0];
					saeq_pkg::REG_OG:   og_q <= cfg_data[16:0];
					saeq_pkg::REG_WET:  wet_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (cmd.wb) begin
				unique case (cmd.step)
					saeq_pkg::STEP_TRIP: begin
						acc_q[cmd.ch][k]  <= saeq_pkg::sat_state(WB'(acc_q[cmd.ch][k]) + f_t);
						acc_q[cmd.ch][pk] <= saeq_pkg::sat_state(WB'(acc_q[cmd.ch][pk]) - f_t);
						tprev_q[cmd.ch]   <= tmid_q[cmd.ch];
						tmid_q[cmd.ch]    <= SB'(x);
					end
					saeq_pkg::STEP_TSC0: acc_q[cmd.ch][0] <= saeq_pkg::sat_state(pw);
					saeq_pkg::STEP_TSC1: acc_q[cmd.ch][1] <= saeq_pkg::sat_state(pw);
					saeq_pkg::STEP_TSC2: acc_q[cmd.ch][2] <= saeq_pkg::sat_state(pw);
					saeq_pkg::STEP_AUPD: begin
						if (use_even) begin
							even_q[cmd.ch][si] <= saeq_pkg::sat_state(WB'(even_q[cmd.ch][si]) + f_a);
							odd_q[cmd.ch][si]  <= saeq_pkg::sat_state(WB'(odd_q[cmd.ch][si]) - f_a);
						end else begin
							odd_q[cmd.ch][si]  <= saeq_pkg::sat_state(WB'(odd_q[cmd.ch][si]) + f_a);
							even_q[cmd.ch][si] <= saeq_pkg::sat_state(WB'(even_q[cmd.ch][si]) - f_a);
						end
						aprev_q[cmd.ch][si] <= SB'(x);
					end
					saeq_pkg::STEP_AODD:  odd_q[cmd.ch][si] <= saeq_pkg::sat_state(pw);
					saeq_pkg::STEP_AEVEN: even_q[cmd.ch][si] <= saeq_pkg::sat_state(pw);
					default: ;
				endcase
			end
			if (cmd.push) begin
				if (alt_q)
					flip1_q <= !flip1_q;
				else
					flip2_q <= !flip2_q;
				alt_q   <= !alt_q;
				phase_q <= (ph_eff == 2'd3) ? 2'd1 : ph_eff + 2'd1;
			end
		end
	end

	assign out_left  = out_l_q;
	assign out_right = out_r_q;

endmodule

### sv/stereo_air_high_shelf_eq.sv
// Stereo high-shelf "air" equalizer with triplet resonator and even/odd air filters.
// The slave stream carries one stereo pair per transfer and the master stream returns
// one processed pair per transfer, in the same order.
// The configuration channel writes one coefficient register per transfer; it is always
// ready and should only be used while no pair is in flight.
// From input transfer to a result ready for output, both channels run 16 steps each
// on one shared 42 x 20 multiplier; each multiply step issues its operands and then
// writes back the registered product, while the other steps write back directly.
// A new pair is accepted only once the previous one has been computed and moved
// into the output register, so pairs are not processed overlapped.
// The finished pair waits in an output register; while the receiver stalls, the next
// pair is still accepted and computed, and then held until the output register drains.
// Reset clears all filter state, sets the coefficients to their defaults and leaves
// both streams empty.
module stereo_air_high_shelf_eq (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // left_sample [23:0], right_sample [47:24]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // left_out [23:0], right_out [47:24]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_data
);

	saeq_pkg::cmd_t cmd;
	logic signed [saeq_pkg::SAMPLE_BITS-1:0] out_left, out_right;

	assign cfg_ready = 1'b1;

	saeq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd)
	);

	saeq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_left   (s_axis_tdata[23:0]),
		.in_right  (s_axis_tdata[47:24]),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_left  (out_left),
		.out_right (out_right)
	);

	assign m_axis_tdata = {out_right, out_left};

endmodule

### sv/saeq_chk.sv
module saeq_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transfer dropped or changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted again right after a transfer");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

	a_no_result_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result appeared one cycle after input transfer");

endmodule

bind stereo_air_high_shelf_eq saeq_chk u_saeq_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);

### tb/saeq_shelf_checker.sv
module saeq_shelf_checker
	import saeq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_data,
	output int          fail_count,
	output int          pairs_in_flight
);

	longint gain_high, gain_trip, gain_air, inv_q, out_gain, wet_mix;
	longint trip_prev [2];
	longint trip_mid [2];
	longint trip_acc [6];
	longint air_last [6];
	longint air_ev [6];
	longint air_od [6];
	int     phase;
	bit     alt_flop, flip_a, flip_b;
	logic [47:0] pairs_due [$];

	function automatic longint clip_state(longint v);
		longint hi;
		hi = (longint'(1) <<< (STATE_BITS - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	function automatic longint clip_sample(longint v);
		longint hi;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	function automatic longint mul_q16(longint a, longint b);
		longint ah;
		longint al;
		ah = a >>> 16;
		al = a & 64'hFFFF;
		return ah * b + ((al * b) >>> 16);
	endfunction

	function automatic longint damp(longint v);
		return clip_state(mul_q16(v, inv_q));
	endfunction

	function automatic longint air_filter(int i, longint x, bit use_even, longint g);
		longint f;
		longint r;
		f = air_last[i] - x;
		if (use_even) begin
			air_ev[i] = clip_state(air_ev[i] + f);
			air_od[i] = clip_state(air_od[i] - f);
			r = mul_q16(air_ev[i], g);
		end else begin
			air_od[i] = clip_state(air_od[i] + f);
			air_ev[i] = clip_state(air_ev[i] - f);
			r = mul_q16(air_od[i], g);
		end
		air_od[i] = damp(air_od[i] - ((air_od[i] - air_ev[i]) >>> 8));
		air_ev[i] = damp(air_ev[i] - ((air_ev[i] - air_od[i]) >>> 8));
		air_last[i] = x;
		return r;
	endfunction

	function automatic longint shelf_channel(int ch, longint x, int ph);
		int     b;
		int     k;
		int     pk;
		longint f;
		longint corr;
		longint y;
		longint w;
		longint mix;
		b = ch * 3;
		k = ph - 1;
		pk = (k + 2) % 3;
		f = trip_prev[ch] - x;
		trip_acc[b + k] = clip_state(trip_acc[b + k] + f);
		trip_acc[b + pk] = clip_state(trip_acc[b + pk] - f);
		corr = mul_q16(trip_acc[b + k], gain_trip);
		trip_prev[ch] = trip_mid[ch];
		trip_mid[ch] = x;
		for (int j = 0; j < 3; j++)
			trip_acc[b + j] = damp(trip_acc[b + j]);
		if (alt_flop)
			corr += air_filter(b, x, flip_a, gain_air);
		else
			corr += air_filter(b + 1, x, flip_b, gain_air);
		corr += air_filter(b + 2, x, alt_flop, gain_high);
		y = mul_q16(clip_state(x + corr), out_gain);
		w = wet_mix > 65536 ? 65536 : wet_mix;
		mix = mul_q16(y, w) + mul_q16(x, 65536 - w);
		return clip_sample(mix >>> UP_SHIFT);
	endfunction

	function automatic logic [47:0] shelf_pair(logic [47:0] d);
		longint xl;
		longint xr;
		longint yl;
		longint yr;
		int     ph;
		xl = $signed(d[23:0]);
		xr = $signed(d[47:24]);
		ph = (phase < 1 || phase > 3) ? 1 : phase;
		yl = shelf_channel(0, xl * 256, ph);
		yr = shelf_channel(1, xr * 256, ph);
		if (alt_flop)
			flip_a = !flip_a;
		else
			flip_b = !flip_b;
		alt_flop = !alt_flop;
		phase = ph == 3 ? 1 : ph + 1;
		return {yr[23:0], yl[23:0]};
	endfunction

	assign pairs_in_flight = pairs_due.size();

	always @(posedge clk or negedge arst_n) begin
		logic [47:0] want;
		int errs;
		if (!arst_n) begin
			gain_high = 0;
			gain_trip = 0;
			gain_air = 0;
			inv_q = IQ_RESET;
			out_gain = UNITY;
			wet_mix = UNITY;
			for (int i = 0; i < 2; i++) begin
				trip_prev[i] = 0;
				trip_mid[i] = 0;
			end
			for (int i = 0; i < 6; i++) begin
				trip_acc[i] = 0;
				air_last[i] = 0;
				air_ev[i] = 0;
				air_od[i] = 0;
			end
			phase = 1;
			alt_flop = 0;
			flip_a = 0;
			flip_b = 0;
			pairs_due.delete();
			fail_count <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HIGH: gain_high = $signed(cfg_data);
					REG_TRIP: gain_trip = $signed(cfg_data[17:0]);
					REG_AIR:  gain_air = $signed(cfg_data[16:0]);
					REG_IQ:   inv_q = cfg_data[15:0];
					REG_OG:   out_gain = cfg_data[16:0];
					REG_WET:  wet_mix = cfg_data[16:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				pairs_due.push_back(shelf_pair(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (pairs_due.size() == 0) begin
					$display("%0t: unexpected pair %h", $realtime, m_axis_tdata);
					errs = errs + 1;
				end else begin
					want = pairs_due.pop_front();
					if (want[23:0] !== m_axis_tdata[23:0]) begin
						$display("%0t: left_out expected %h actual %h", $realtime,
							want[23:0], m_axis_tdata[23:0]);
						errs = errs + 1;
					end
					if (want[47:24] !== m_axis_tdata[47:24]) begin
						$display("%0t: right_out expected %h actual %h", $realtime,
							want[47:24], m_axis_tdata[47:24]);
						errs = errs + 1;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

### tb/tb_stereo_air_high_shelf_eq.sv
module tb_stereo_air_high_shelf_eq;
	import saeq_pkg::*;

	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;
	localparam int IDLE_LIMIT = 20000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 210;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [18:0] cfg_data;
	int          fail_count;
	int          pairs_in_flight;
	int          pairs_out;
	int          idle_cycles;
	bit          steady_sender;

	stereo_air_high_shelf_eq uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	saeq_shelf_checker shelf_check (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pairs_in_flight(pairs_in_flight)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3, 4, 5: return 24'($signed($urandom_range(0, 8192)) - 4096);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [18:0] pick_signed(int range);
		return 19'($signed($urandom_range(0, 2 * range)) - range);
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [18:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic send_pair(logic [23:0] left, logic [23:0] right);
		int gap;
		gap = steady_sender ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {right, left};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pairs_in_flight != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(int p);
		case (p)
			0: begin
				write_reg(REG_HIGH, 19'(131072));
				write_reg(REG_TRIP, 19'(65536));
				write_reg(REG_AIR, 19'(32768));
				write_reg(REG_IQ, 19'(59578));
				write_reg(REG_OG, 19'(65536));
				write_reg(REG_WET, 19'(65536));
			end
			1: begin
				write_reg(REG_HIGH, 19'(-131072));
				write_reg(REG_TRIP, 19'(-65536));
				write_reg(REG_AIR, 19'(-32768));
				write_reg(REG_IQ, 19'(31208));
				write_reg(REG_OG, 19'(0));
				write_reg(REG_WET, 19'(0));
			end
			2: begin
				write_reg(REG_IQ, 19'(0));
				write_reg(REG_OG, 19'(131071));
				write_reg(REG_WET, 19'(100000));
				write_reg(REG_SPARE_6, 19'h7FFFF);
				write_reg(REG_SPARE_7, 19'h12345);
			end
			3: begin
				write_reg(REG_HIGH, 19'h7FFFF);
				write_reg(REG_TRIP, 19'h1FFFF);
				write_reg(REG_AIR, 19'h0FFFF);
				write_reg(REG_IQ, 19'hFFFF);
				write_reg(REG_OG, 19'h1FFFF);
				write_reg(REG_WET, 19'h1FFFF);
			end
			default: begin
				write_reg(REG_HIGH, pick_signed(131072));
				write_reg(REG_TRIP, pick_signed(65536));
				write_reg(REG_AIR, pick_signed(32768));
				write_reg(REG_IQ, 19'($urandom_range(31208, 59578)));
				write_reg(REG_OG, 19'($urandom_range(0, 70000)));
				write_reg(REG_WET, 19'($urandom_range(0, 65536)));
			end
		endcase
		cfg_valid <= 0;
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		cfg_valid = 0;
		cfg_index = REG_HIGH;
		cfg_data = '0;
		steady_sender = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_pair(24'h7FFFFF, 24'h800000);
		send_pair(24'h800000, 24'h7FFFFF);
		send_pair(24'h000000, 24'h000000);
		drain();
		configure(0);
		send_pair(24'h7FFFFF, 24'h7FFFFF);
		send_pair(24'h800000, 24'h800000);
		for (int i = 0; i < 8; i++)
			send_pair(i[0] ? 24'h7FFFFF : 24'h800000, i[0] ? 24'h800000 : 24'h7FFFFF);
		send_pair(24'h000001, 24'hFFFFFF);
		send_pair(24'h555555, 24'hAAAAAA);
		drain();
		configure(2);
		for (int i = 0; i < 6; i++)
			send_pair(i[0] ? 24'h7FFFFF : 24'h800000, 24'h400000);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			configure(p == 0 ? 4 : p);
			steady_sender = (p == 5);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_pair(pick_sample(), pick_sample());
			steady_sender = 0;
			drain();
		end

		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("stereo_air_high_shelf_eq: match");
		else
			$display("stereo_air_high_shelf_eq: mismatch");
		$finish;
	end

	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		while (pairs_out < 300) begin
			gap = pick_gap();
			if (gap > 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		m_axis_tready <= 0;
		repeat (900) @(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			repeat ($urandom_range(1, 200)) @(posedge clk);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_out <= 0;
			idle_cycles <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				pairs_out <= pairs_out + 1;
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("stereo_air_high_shelf_eq: mismatch");
				$finish;
			end
		end
	end

endmodule

### stereo_air_high_shelf_eq.f
sv/saeq_pkg.sv
sv/saeq_ctrl.sv
sv/saeq_dp.sv
sv/stereo_air_high_shelf_eq.sv
sv/saeq_chk.sv
tb/saeq_shelf_checker.sv
tb/tb_stereo_air_high_shelf_eq.sv
